>>> src/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;          // one product
    localparam int SW        = PW + 1;          // sum of two products
    localparam int NW        = SW + FRAC_BITS;  // scaled numerator magnitude
    localparam int QSTEPS    = FRAC_BITS + DW + 2; // quotient bits that matter
    localparam int QW        = QSTEPS;
    localparam int DENW      = PW + 1;          // br^2 + bi^2

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic signed [SW-1:0]  re;   // exact sum or numerator
        logic signed [SW-1:0]  im;
        logic [DENW-1:0]       den;
    } prod_t;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          ovf;
        logic          dz;
    } res_t;

    // Saturate a signed value held in NW+1 bits to 32 bits.
    function automatic logic [DW:0] sat32(input logic signed [NW:0] v);
        logic signed [NW:0] hi;
        logic signed [NW:0] lo;
        hi = (NW+1)'(2147483647);
        lo = -(NW+1)'(64'sd2147483648);
        if (v > hi)
            sat32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < lo)
            sat32 = {1'b1, 32'h8000_0000};
        else
            sat32 = {1'b0, v[DW-1:0]};
    endfunction

endpackage

>>> src/cau_mult.sv
`timescale 1ns / 1ps
// Two-stage product stage: six 32x32 products, then sums and the divisor |b|^2.
module cau_mult
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cau_pkg::op_t          in_op,
    input  logic signed [31:0]    a_re,
    input  logic signed [31:0]    a_im,
    input  logic signed [31:0]    b_re,
    input  logic signed [31:0]    b_im,
    output logic                  out_valid,
    output cau_pkg::prod_t        out_prod
);
    import cau_pkg::*;

    logic                 v1_reg;
    op_t                  op1_reg;
    logic signed [PW-1:0] rr_reg, ii_reg, ri_reg, ir_reg, bb_reg, qq_reg;
    logic signed [SW-1:0] add_re_reg, add_im_reg;
    logic                 v2_reg;
    prod_t                p2_reg;
    prod_t                p2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= in_op;
            rr_reg  <= a_re * b_re;
            ii_reg  <= a_im * b_im;
            ri_reg  <= a_re * b_im;
            ir_reg  <= a_im * b_re;
            bb_reg  <= b_re * b_re;
            qq_reg  <= b_im * b_im;
            if (in_op == OP_SUB)
            begin
                add_re_reg <= SW'(a_re) - SW'(b_re);
                add_im_reg <= SW'(a_im) - SW'(b_im);
            end
            else
            begin
                add_re_reg <= SW'(a_re) + SW'(b_re);
                add_im_reg <= SW'(a_im) + SW'(b_im);
            end
            p2_reg <= p2_next;
        end
    end

    always_comb
    begin
        p2_next.op  = op1_reg;
        p2_next.den = DENW'($unsigned(bb_reg)) + DENW'($unsigned(qq_reg));
        unique case (op1_reg)
            OP_MUL:
            begin
                p2_next.re = SW'(rr_reg) - SW'(ii_reg);
                p2_next.im = SW'(ri_reg) + SW'(ir_reg);
            end
            OP_DIV:
            begin
                p2_next.re = SW'(rr_reg) + SW'(ii_reg);
                p2_next.im = SW'(ir_reg) - SW'(ri_reg);
            end
            default:
            begin
                p2_next.re = add_re_reg;
                p2_next.im = add_im_reg;
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_prod  = p2_reg;
endmodule

>>> src/cau_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage for both parts.
// The numerator is below 2^(2*DW+1+FRAC_BITS); a zero den sets dz. Quotient
// bits above QSTEPS only mean saturation, so they fold into a sticky flag.
module cau_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  cau_pkg::prod_t   in_prod,
    output logic             out_valid,
    output cau_pkg::res_t    out_res
);
    import cau_pkg::*;

    localparam int RW = DENW + 1;

    // per-stage registers
    logic              v_reg   [QSTEPS+1];
    op_t               op_reg  [QSTEPS+1];
    logic [DENW-1:0]   den_reg [QSTEPS+1];
    logic [NW-1:0]     nr_reg  [QSTEPS+1];  // remaining numerator bits, real
    logic [NW-1:0]     ni_reg  [QSTEPS+1];
    logic [RW-1:0]     rr_reg  [QSTEPS+1];  // partial remainder
    logic [RW-1:0]     ri_reg  [QSTEPS+1];
    logic [QW-1:0]     qr_reg  [QSTEPS+1];
    logic [QW-1:0]     qi_reg  [QSTEPS+1];
    logic              sr_reg  [QSTEPS+1];  // sign of numerator
    logic              si_reg  [QSTEPS+1];
    logic              big_reg [QSTEPS+1];  // quotient too large: saturate
    logic              bigi_reg[QSTEPS+1];
    logic signed [SW-1:0] pre_reg [QSTEPS+1]; // add/sub/mul pass-through
    logic signed [SW-1:0] pim_reg [QSTEPS+1];

    logic              ov_reg;
    res_t              res_reg;

    res_t res_next;
    logic [DW:0] sat_re, sat_im;
    logic signed [NW:0] val_re, val_im;

    // stage 0: magnitudes and the high-part check
    logic [SW-1:0]     mag_re, mag_im;
    logic [NW-1:0]     sh_re, sh_im;

    always_comb
    begin
        mag_re = in_prod.re[SW-1] ? SW'(-in_prod.re) : SW'(in_prod.re);
        mag_im = in_prod.im[SW-1] ? SW'(-in_prod.im) : SW'(in_prod.im);
        sh_re  = {mag_re, {FRAC_BITS{1'b0}}};
        sh_im  = {mag_im, {FRAC_BITS{1'b0}}};
    end

    // The top NW-QSTEPS numerator bits are compared against den once:
    // if that leading chunk is >= den the quotient is >= 2^QSTEPS.
    localparam int HB = NW - QSTEPS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QSTEPS; s++)
                v_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= QSTEPS; s++)
                v_reg[s] <= v_reg[s-1];
            ov_reg <= v_reg[QSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]   <= in_prod.op;
            den_reg[0]  <= in_prod.den;
            nr_reg[0]   <= sh_re << HB;
            ni_reg[0]   <= sh_im << HB;
            rr_reg[0]   <= RW'(sh_re[NW-1 -: HB]);
            ri_reg[0]   <= RW'(sh_im[NW-1 -: HB]);
            qr_reg[0]   <= '0;
            qi_reg[0]   <= '0;
            sr_reg[0]   <= in_prod.re[SW-1];
            si_reg[0]   <= in_prod.im[SW-1];
            big_reg[0]  <= RW'(sh_re[NW-1 -: HB]) >= RW'(in_prod.den);
            bigi_reg[0] <= RW'(sh_im[NW-1 -: HB]) >= RW'(in_prod.den);
            pre_reg[0]  <= in_prod.re;
            pim_reg[0]  <= in_prod.im;
            for (int s = 1; s <= QSTEPS; s++)
            begin
                logic [RW-1:0] tr, ti;
                tr = {rr_reg[s-1][RW-2:0], nr_reg[s-1][NW-1]};
                ti = {ri_reg[s-1][RW-2:0], ni_reg[s-1][NW-1]};
                op_reg[s]   <= op_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                nr_reg[s]   <= nr_reg[s-1] << 1;
                ni_reg[s]   <= ni_reg[s-1] << 1;
                sr_reg[s]   <= sr_reg[s-1];
                si_reg[s]   <= si_reg[s-1];
                big_reg[s]  <= big_reg[s-1];
                bigi_reg[s] <= bigi_reg[s-1];
                pre_reg[s]  <= pre_reg[s-1];
                pim_reg[s]  <= pim_reg[s-1];
                if (tr >= RW'(den_reg[s-1]))
                begin
                    rr_reg[s] <= tr - RW'(den_reg[s-1]);
                    qr_reg[s] <= {qr_reg[s-1][QW-2:0], 1'b1};
                end
                else
                begin
                    rr_reg[s] <= tr;
                    qr_reg[s] <= {qr_reg[s-1][QW-2:0], 1'b0};
                end
                if (ti >= RW'(den_reg[s-1]))
                begin
                    ri_reg[s] <= ti - RW'(den_reg[s-1]);
                    qi_reg[s] <= {qi_reg[s-1][QW-2:0], 1'b1};
                end
                else
                begin
                    ri_reg[s] <= ti;
                    qi_reg[s] <= {qi_reg[s-1][QW-2:0], 1'b0};
                end
            end
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        unique case (op_reg[QSTEPS])
            OP_MUL:
            begin
                val_re = (NW+1)'(pre_reg[QSTEPS] >>> FRAC_BITS);
                val_im = (NW+1)'(pim_reg[QSTEPS] >>> FRAC_BITS);
            end
            OP_DIV:
            begin
                if (big_reg[QSTEPS])
                    val_re = sr_reg[QSTEPS] ? -(NW+1)'(64'sh1_0000_0000)
                                            : (NW+1)'(64'sh1_0000_0000);
                else
                    val_re = sr_reg[QSTEPS] ? -(NW+1)'(qr_reg[QSTEPS])
                                            : (NW+1)'(qr_reg[QSTEPS]);
                if (bigi_reg[QSTEPS])
                    val_im = si_reg[QSTEPS] ? -(NW+1)'(64'sh1_0000_0000)
                                            : (NW+1)'(64'sh1_0000_0000);
                else
                    val_im = si_reg[QSTEPS] ? -(NW+1)'(qi_reg[QSTEPS])
                                            : (NW+1)'(qi_reg[QSTEPS]);
            end
            default:
            begin
                val_re = (NW+1)'(pre_reg[QSTEPS]);
                val_im = (NW+1)'(pim_reg[QSTEPS]);
            end
        endcase
        sat_re = sat32(val_re);
        sat_im = sat32(val_im);
        if (op_reg[QSTEPS] == OP_DIV && den_reg[QSTEPS] == '0)
        begin
            res_next.re  = '0;
            res_next.im  = '0;
            res_next.ovf = 1'b0;
            res_next.dz  = 1'b1;
        end
        else
        begin
            res_next.re  = sat_re[DW-1:0];
            res_next.im  = sat_im[DW-1:0];
            res_next.ovf = sat_re[DW] | sat_im[DW];
            res_next.dz  = 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = res_reg;
endmodule

>>> src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex add, subtract, multiply and divide on signed Q16.16 operands. One
// item is taken per clock while the output is not stalled. Every item
// passes through the product stages and the bit-per-stage divider
// pipeline, so order is kept. The whole pipe advances only when the
// output register is empty or being read, so a stall holds everything.
// Division truncates toward zero; a zero divisor gives zero parts and sets
// div_by_zero; saturated parts set overflow.
module complex_arithmetic_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]    s_tuser,  // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,  // res_re, res_im
    output logic [1:0]    m_tuser   // overflow, div_by_zero
);
    import cau_pkg::*;

    logic  en;
    logic  pv;
    prod_t pp;
    res_t  rr;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_mult u_mult
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_op    (op_t'(s_tuser)),
        .a_re     (s_tdata[31:0]),
        .a_im     (s_tdata[63:32]),
        .b_re     (s_tdata[95:64]),
        .b_im     (s_tdata[127:96]),
        .out_valid(pv),
        .out_prod (pp)
    );

    cau_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pv),
        .in_prod  (pp),
        .out_valid(m_tvalid),
        .out_res  (rr)
    );

    assign m_tdata = {rr.im, rr.re};
    assign m_tuser = {rr.dz, rr.ovf};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
        else $error("divide by zero result not clean");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
endmodule
